>>> rtl/core/brf_pkg.sv
`default_nettype none

package brf_pkg;

  // Default sizing
  localparam int CAPACITY_DEF = 1023;
  localparam int LANES_DEF    = 8;

  // Fixed field widths
  localparam int TYPE_W = 3;
  localparam int CNT_FW = 10;
  localparam int DATA_W = 64;

  // Segment length (0..8) and byte position inside an item (0..7)
  localparam int LEN_W = 4;
  localparam int POS_W = 3;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_ENQ      = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_DEQ      = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_PEEK     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_ADV_TAIL = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_ADV_HEAD = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_CLEAR    = 3'd5;

  // One contiguous run of bytes handed to all lanes
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] off;
  } seg_cmd_t;

  // Read byte returned by a lane
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } lane_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/brf_lane.sv
`default_nettype none

module brf_lane #(
  parameter int PTR_W   = 10,
  parameter int BANK_W  = 3,
  parameter int ROWS    = 128,
  parameter int ROW_W   = 7,
  parameter int BANK_ID = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  brf_pkg::seg_cmd_t        cmd_i,
  input  logic [PTR_W-1:0]         start_i,
  input  logic [brf_pkg::DATA_W-1:0] wdata_i,
  input  logic                     clr_i,
  input  logic [ROW_W-1:0]         clr_row_i,
  output brf_pkg::lane_rsp_t       rsp_o
);
  import brf_pkg::*;

  logic [7:0]       mem_q [ROWS];
  logic [BANK_W-1:0] k;
  logic             hit;
  logic [PTR_W-1:0] addr;
  logic [ROW_W-1:0] row;
  logic [POS_W-1:0] pos;
  logic [7:0]       wbyte;
  logic             we;
  logic [ROW_W-1:0] waddr;
  logic [7:0]       wd;
  logic             re;
  logic             rsp_valid_q;
  logic [POS_W-1:0] rsp_pos_q;
  logic [7:0]       rsp_data_q;

  // Offset of this bank inside the run; every bank takes at most one byte
  assign k     = BANK_W'(BANK_ID) - BANK_W'(start_i);
  assign hit   = (LEN_W'(k) < cmd_i.len);
  assign addr  = start_i + PTR_W'(k);
  assign row   = ROW_W'(addr >> BANK_W);
  assign pos   = cmd_i.off + POS_W'(k);
  assign wbyte = wdata_i[{pos, 3'b000} +: 8];

  // Single write port shared with the clearing pass
  assign we    = clr_i | (cmd_i.wr & hit);
  assign waddr = clr_i ? clr_row_i : row;
  assign wd    = clr_i ? 8'h00 : wbyte;
  assign re    = cmd_i.rd & hit;

  // Byte bank, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wd;
    end
    if (re) begin
      rsp_data_q <= mem_q[row];
    end
    rsp_pos_q <= pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= re;
    end
  end

  assign rsp_o = '{valid: rsp_valid_q, pos: rsp_pos_q, data: rsp_data_q};

endmodule

`default_nettype wire

>>> rtl/core/brf_merge.sv
`default_nettype none

module brf_merge #(
  parameter int NBANK = 8
) (
  input  brf_pkg::lane_rsp_t         rsp_i [NBANK],
  output logic [brf_pkg::DATA_W-1:0] word_o
);
  import brf_pkg::*;

  // Steer each returned byte to its place in the item
  always_comb begin
    word_o = '0;
    for (int b = 0; b < NBANK; b++) begin
      if (rsp_i[b].valid) begin
        word_o[{rsp_i[b].pos, 3'b000} +: 8] = word_o[{rsp_i[b].pos, 3'b000} +: 8]
                                              | rsp_i[b].data;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/byte_ring_fifo.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i/in_stall_o   | req_type_i, count_i, data_i
// out     | output    | out_valid_o/out_stall_i | status_o, done_count_o, read_data_o,
//         |           |                         | used_count_o, free_count_o
//
// One item at a time. The result is loaded in the last step of the sequencer, after a
// second pass over the byte banks when a transfer wraps past the last slot. The next
// item can be taken in the cycle after the result is loaded. The steps are set by
// the sequencer: decide, bank access (one or two runs), read return, result load.
// Reset clears pointers and starts a clearing pass that zeroes the byte banks; input
// is stalled during it. A held result keeps the sequencer in its last step, so input
// stays stalled until that result is taken.
`default_nettype none

module byte_ring_fifo #(
  parameter int CAPACITY = brf_pkg::CAPACITY_DEF,
  parameter int LANES    = brf_pkg::LANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [brf_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [brf_pkg::CNT_FW-1:0]  count_i,
  input  logic [brf_pkg::DATA_W-1:0]  data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [brf_pkg::CNT_FW-1:0]  done_count_o,
  output logic [brf_pkg::DATA_W-1:0]  read_data_o,
  output logic [brf_pkg::CNT_FW-1:0]  used_count_o,
  output logic [brf_pkg::CNT_FW-1:0]  free_count_o
);
  import brf_pkg::*;

  localparam int SLOTS  = CAPACITY + 1;
  localparam int PTR_W  = $clog2(SLOTS);
  localparam int BANK_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NBANK  = 1 << BANK_W;
  localparam int ROWS   = (SLOTS + NBANK - 1) / NBANK;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W  = (PTR_W > CNT_FW) ? PTR_W : CNT_FW;
  localparam int AW     = CMP_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SEG1  = 3'd3;
  localparam logic [2:0] ST_SEG2  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [ROW_W-1:0]  clr_row_q;
  logic              in_acc;
  logic              out_free;

  logic [TYPE_W-1:0] req_type_q;
  logic [CNT_FW-1:0] cnt_q;
  logic [DATA_W-1:0] data_q;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  used_q, used_d;
  logic [PTR_W-1:0]  free_now;

  logic              ok_q, ok_d;
  logic [CNT_FW-1:0] done_q, done_d;
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [LEN_W-1:0]  n_q, n1_q, n1_d;

  logic              le_lanes, fits_free, fits_used;
  logic [AW-1:0]     head_sum, tail_sum, room;
  logic [PTR_W-1:0]  head_adv, tail_adv;

  seg_cmd_t          cmd;
  logic [PTR_W-1:0]  seg_start;
  lane_rsp_t         rsp [NBANK];
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] acc_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [CNT_FW-1:0] out_done_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CNT_FW-1:0] out_used_q;
  logic [CNT_FW-1:0] out_free_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Space checks and wrapped pointer advances
  assign free_now  = PTR_W'(CAPACITY) - used_q;
  assign le_lanes  = (AW'(cnt_q) <= AW'(LANES));
  assign fits_free = (AW'(cnt_q) <= AW'(free_now));
  assign fits_used = (AW'(cnt_q) <= AW'(used_q));
  assign head_sum  = AW'(head_q) + AW'(cnt_q);
  assign tail_sum  = AW'(tail_q) + AW'(cnt_q);
  assign head_adv  = PTR_W'((head_sum >= AW'(SLOTS)) ? head_sum - AW'(SLOTS) : head_sum);
  assign tail_adv  = PTR_W'((tail_sum >= AW'(SLOTS)) ? tail_sum - AW'(SLOTS) : tail_sum);

  // Request decode
  always_comb begin
    ok_d   = 1'b0;
    wr_d   = 1'b0;
    rd_d   = 1'b0;
    ptr_d  = head_q;
    head_d = head_q;
    tail_d = tail_q;
    used_d = used_q;
    done_d = '0;
    case (req_type_q)
      REQ_ENQ: begin
        if (le_lanes && fits_free) begin
          ok_d   = 1'b1;
          wr_d   = 1'b1;
          ptr_d  = tail_q;
          tail_d = tail_adv;
          used_d = used_q + PTR_W'(cnt_q);
          done_d = cnt_q;
        end
      end
      REQ_DEQ: begin
        if (le_lanes && fits_used) begin
          ok_d   = 1'b1;
          rd_d   = 1'b1;
          head_d = head_adv;
          used_d = used_q - PTR_W'(cnt_q);
          done_d = cnt_q;
        end
      end
      REQ_PEEK: begin
        if (le_lanes && fits_used) begin
          ok_d   = 1'b1;
          rd_d   = 1'b1;
          done_d = cnt_q;
        end
      end
      REQ_ADV_TAIL: begin
        if (fits_free) begin
          ok_d   = 1'b1;
          tail_d = tail_adv;
          used_d = used_q + PTR_W'(cnt_q);
          done_d = cnt_q;
        end
      end
      REQ_ADV_HEAD: begin
        if (fits_used) begin
          ok_d   = 1'b1;
          head_d = head_adv;
          used_d = used_q - PTR_W'(cnt_q);
          done_d = cnt_q;
        end
      end
      REQ_CLEAR: begin
        ok_d   = 1'b1;
        head_d = tail_q;
        used_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // First run stops at the last slot
  assign room = AW'(SLOTS) - AW'(ptr_d);
  assign n1_d = (AW'(cnt_q) > room) ? LEN_W'(room) : LEN_W'(cnt_q);

  // Run handed to the lanes
  always_comb begin
    cmd       = '0;
    seg_start = ptr_q;
    case (state_q)
      ST_SEG1: begin
        cmd = '{wr: wr_q, rd: rd_q, len: n1_q, off: '0};
      end
      ST_SEG2: begin
        cmd       = '{wr: wr_q, rd: rd_q, len: n_q - n1_q, off: POS_W'(n1_q)};
        seg_start = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Sequencer; only a byte transfer takes the second run
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_row_q == ROW_W'(ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_SEG1;
      ST_SEG1:  state_d = ((wr_q | rd_q) && (n1_q != n_q)) ? ST_SEG2 : ST_DRAIN;
      ST_SEG2:  state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      used_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_row_q <= clr_row_q + 1'b1;
      end
      if (state_q == ST_EXEC) begin
        head_q <= head_d;
        tail_q <= tail_d;
        used_q <= used_d;
      end
    end
  end

  // Request and decision payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_type_q <= req_type_i;
      cnt_q      <= count_i;
      data_q     <= data_i;
    end
    if (state_q == ST_EXEC) begin
      ok_q   <= ok_d;
      done_q <= done_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      ptr_q  <= ptr_d;
      n_q    <= LEN_W'(cnt_q);
      n1_q   <= n1_d;
    end
    acc_q <= in_acc ? '0 : (acc_q | merged);
  end

  // Byte lanes, one bank each
  for (genvar b = 0; b < NBANK; b++) begin : g_lane
    brf_lane #(
      .PTR_W  (PTR_W),
      .BANK_W (BANK_W),
      .ROWS   (ROWS),
      .ROW_W  (ROW_W),
      .BANK_ID(b)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .start_i  (seg_start),
      .wdata_i  (data_q),
      .clr_i    (state_q == ST_CLEAR),
      .clr_row_i(clr_row_q),
      .rsp_o    (rsp[b])
    );
  end

  brf_merge #(
    .NBANK(NBANK)
  ) u_merge (
    .rsp_i (rsp),
    .word_o(merged)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_status_q <= ~ok_q;
      out_done_q   <= done_q;
      out_data_q   <= acc_q;
      out_used_q   <= CNT_FW'(used_q);
      out_free_q   <= CNT_FW'(free_now);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign done_count_o = out_done_q;
  assign read_data_o  = out_data_q;
  assign used_count_o = out_used_q;
  assign free_count_o = out_free_q;

endmodule

`default_nettype wire

>>> rtl/core/brf_checker.sv
`default_nettype none

module brf_checker #(
  parameter int CAPACITY = brf_pkg::CAPACITY_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic [brf_pkg::CNT_FW-1:0]  done_count_o,
  input logic [brf_pkg::DATA_W-1:0]  read_data_o,
  input logic [brf_pkg::CNT_FW-1:0]  used_count_o,
  input logic [brf_pkg::CNT_FW-1:0]  free_count_o
);
  import brf_pkg::*;

  // Used plus free always adds up to the capacity
  a_space_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CNT_FW'(used_count_o + free_count_o) == CNT_FW'(CAPACITY)))
    else $error("used plus free differs from capacity");

  // A rejected item moves nothing and returns no bytes
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (done_count_o == '0 && read_data_o == '0))
    else $error("rejected item reports bytes");

  // One item in flight: input is held off right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in work");

  // A stalled result stays valid, with its read data and used count held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)
                                      && $stable(used_count_o)))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo brf_checker #(
  .CAPACITY(CAPACITY)
) u_brf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .done_count_o(done_count_o),
  .read_data_o (read_data_o),
  .used_count_o(used_count_o),
  .free_count_o(free_count_o)
);

`default_nettype wire

>>> verif/byte_ring_fifo_tb.sv
`default_nettype none

module byte_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int          FIFO_CAP    = CAPACITY_DEF;
  localparam int          FIFO_LANES  = LANES_DEF;
  localparam int unsigned STORE_SLOTS = FIFO_CAP + 1;
  localparam int          HOLD_CYCLES = 300;
  localparam int          POST_CYCLES = 12;
  localparam int          MAX_REPORTS = 40;

  // Codes the block has no operation for
  localparam logic [TYPE_W-1:0] REQ_UNDEF_A = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_UNDEF_B = 3'd7;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic              status;
    logic [CNT_FW-1:0] done;
    logic [DATA_W-1:0] rdata;
    logic [CNT_FW-1:0] used;
    logic [CNT_FW-1:0] free;
  } fifo_result_t;

  // Tracks the ring contents and the results each request should produce
  class ring_tracker;
    logic [7:0]   store [STORE_SLOTS];
    int unsigned  head;
    int unsigned  tail;
    fifo_result_t pending_results [$];
    int           errors;
    int           checked;
    int           accepted;
    int           rejected;
    int           head_laps;
    int           tail_laps;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      head = 0;
      tail = 0;
    endfunction

    function int unsigned used_bytes();
      return (head <= tail) ? tail - head : STORE_SLOTS - head + tail;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void move_head(int unsigned n);
      if (head + n >= STORE_SLOTS) head_laps++;
      head = (head + n) % STORE_SLOTS;
    endfunction

    function void move_tail(int unsigned n);
      if (tail + n >= STORE_SLOTS) tail_laps++;
      tail = (tail + n) % STORE_SLOTS;
    endfunction

    // Apply one accepted request and queue its result
    function void note_request(logic [TYPE_W-1:0] kind, logic [CNT_FW-1:0] cnt,
                               logic [DATA_W-1:0] data);
      int unsigned  used;
      int unsigned  room;
      int unsigned  n;
      int unsigned  i;
      logic         ok;
      logic [63:0]  rd;
      fifo_result_t r;
      used = used_bytes();
      room = FIFO_CAP - used;
      n    = 32'(cnt);
      ok   = 1'b1;
      rd   = '0;
      case (kind)
        REQ_ENQ: begin
          if (n > FIFO_LANES || n > room) ok = 1'b0;
          else begin
            for (i = 0; i < n; i++) begin
              store[tail] = data[8*i +: 8];
              move_tail(1);
            end
          end
        end
        REQ_DEQ, REQ_PEEK: begin
          if (n > FIFO_LANES || n > used) ok = 1'b0;
          else begin
            for (i = 0; i < n; i++) rd[8*i +: 8] = store[(head + i) % STORE_SLOTS];
            if (kind == REQ_DEQ) move_head(n);
          end
        end
        REQ_ADV_TAIL: begin
          if (n > room) ok = 1'b0;
          else move_tail(n);
        end
        REQ_ADV_HEAD: begin
          if (n > used) ok = 1'b0;
          else move_head(n);
        end
        REQ_CLEAR: begin
          head = tail;
          n = 0;
        end
        default: ok = 1'b0;
      endcase
      used     = used_bytes();
      r.status = ok ? ST_OK : ST_REJECT;
      r.done   = ok ? n[CNT_FW-1:0] : '0;
      r.rdata  = rd;
      r.used   = used[CNT_FW-1:0];
      r.free   = CNT_FW'(FIFO_CAP - used);
      if (ok) accepted++;
      else rejected++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Compare one result from the block against the oldest expectation
    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual 0x%0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("done_count", 64'(want.done), 64'(got.done));
      compare_field("read_data", want.rdata, got.rdata);
      compare_field("used_count", 64'(want.used), 64'(got.used));
      compare_field("free_count", 64'(want.free), 64'(got.free));
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [TYPE_W-1:0] req_type_i   = '0;
  logic [CNT_FW-1:0] count_i      = '0;
  logic [DATA_W-1:0] data_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic              status_o;
  logic [CNT_FW-1:0] done_count_o;
  logic [DATA_W-1:0] read_data_o;
  logic [CNT_FW-1:0] used_count_o;
  logic [CNT_FW-1:0] free_count_o;

  ring_tracker ring = new();
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;

  byte_ring_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .count_i     (count_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .done_count_o(done_count_o),
    .read_data_o (read_data_o),
    .used_count_o(used_count_o),
    .free_count_o(free_count_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      ring.check_result({status_o, done_count_o, read_data_o, used_count_o, free_count_o});
  end

  // Offer one request, wait for it to be taken, then log it
  task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [CNT_FW-1:0] cnt,
                              input logic [DATA_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    count_i    <= cnt;
    data_i     <= data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ring.note_request(kind, cnt, data);
  endtask

  // Mostly legal transfer sizes, now and then oversized ones
  function automatic logic [CNT_FW-1:0] transfer_count();
    if ($urandom_range(0, 99) < 88) return CNT_FW'($urandom_range(0, FIFO_LANES));
    return CNT_FW'($urandom_range(0, 1023));
  endfunction

  // Advance counts up to the limit, at the limit, just over it, or anything
  function automatic logic [CNT_FW-1:0] advance_count(int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return CNT_FW'($urandom_range(0, limit));
    if (r == 6) return CNT_FW'(limit);
    if (r == 7) return CNT_FW'((limit < FIFO_CAP) ? limit + 1 : limit);
    return CNT_FW'($urandom_range(0, 1023));
  endfunction

  task automatic random_requests(input int n);
    int unsigned       pick;
    int unsigned       used;
    logic [TYPE_W-1:0] kind;
    logic [CNT_FW-1:0] cnt;
    logic [DATA_W-1:0] data;
    repeat (n) begin
      used = ring.used_bytes();
      data = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        kind = REQ_ENQ;
        cnt  = transfer_count();
      end else if (pick < 52) begin
        kind = REQ_DEQ;
        cnt  = transfer_count();
      end else if (pick < 62) begin
        kind = REQ_PEEK;
        cnt  = transfer_count();
      end else if (pick < 72) begin
        kind = REQ_ADV_TAIL;
        cnt  = advance_count(FIFO_CAP - used);
      end else if (pick < 82) begin
        kind = REQ_ADV_HEAD;
        cnt  = advance_count(used);
      end else if (pick < 85) begin
        kind = REQ_CLEAR;
        cnt  = CNT_FW'($urandom_range(0, 1023));
      end else begin
        // noise: any code, any count
        kind = TYPE_W'($urandom_range(0, 7));
        cnt  = CNT_FW'($urandom_range(0, 1023));
      end
      send_request(kind, cnt, data);
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ring.pending() != 0) @(posedge clk_i);
    repeat (POST_CYCLES) @(posedge clk_i);
  endtask

  // Directed corner cases
  task automatic directed_requests();
    send_request(REQ_PEEK, 10'd0, 64'h0);                        // zero count on empty
    send_request(REQ_DEQ, 10'd1, 64'h0);                         // no data
    send_request(REQ_ENQ, 10'd8, 64'h0123_4567_89ab_cdef);
    send_request(REQ_ENQ, 10'd3, 64'hffff_ffff_ffff_ffff);       // upper bytes ignored
    send_request(REQ_PEEK, 10'd8, 64'h0);
    send_request(REQ_DEQ, 10'd9, 64'h0);                         // oversized
    send_request(REQ_ENQ, 10'd0, 64'hdead_beef_dead_beef);
    send_request(REQ_DEQ, 10'd8, 64'h0);
    send_request(REQ_DEQ, 10'd3, 64'h0);
    send_request(REQ_ADV_HEAD, 10'd1, 64'h0);                    // empty
    send_request(REQ_ADV_TAIL, 10'd1023, 64'h0);                 // exactly full
    send_request(REQ_ENQ, 10'd1, 64'h55);                        // full
    send_request(REQ_ADV_TAIL, 10'd1, 64'h0);                    // full
    send_request(REQ_ADV_HEAD, 10'd1020, 64'h0);
    send_request(REQ_ENQ, 10'd8, 64'hfedc_ba98_7654_3210);
    send_request(REQ_PEEK, 10'd8, 64'h0);
    send_request(REQ_DEQ, 10'd8, 64'h0);
    send_request(REQ_CLEAR, 10'd5, 64'h0);
    send_request(REQ_UNDEF_A, 10'd5, 64'h0);
    send_request(REQ_UNDEF_B, 10'd1023, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_ENQ, 10'd1023, 64'h0);                      // oversized enqueue
    send_request(REQ_ADV_TAIL, 10'd1023, 64'h0);                 // full across the wrap
    send_request(REQ_ADV_HEAD, 10'd1023, 64'h0);
    send_request(REQ_ENQ, 10'd8, 64'h0);
    send_request(REQ_DEQ, 10'd8, 64'h0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Slow receiver
    send_idle_pct = 30;
    recv_idle_pct = 70;
    directed_requests();
    random_requests(100);
    hold_req = 1'b1;
    random_requests(250);
    drain();

    // Slow sender
    send_idle_pct = 70;
    recv_idle_pct = 30;
    random_requests(375);
    drain();

    // Full rate, with one more long hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(150);
    hold_req = 1'b1;
    random_requests(225);
    drain();

    $display("checked %0d results: %0d requests accepted, %0d rejected",
             ring.checked, ring.accepted, ring.rejected);
    $display("head wrapped %0d times, tail wrapped %0d times", ring.head_laps, ring.tail_laps);
    if (ring.errors == 0 && ring.pending() == 0) begin
      $display("byte_ring_fifo regression: pass");
    end else begin
      $display("byte_ring_fifo regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", ring.pending());
    $display("byte_ring_fifo regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/brf_pkg.sv
rtl/core/brf_lane.sv
rtl/core/brf_merge.sv
rtl/core/byte_ring_fifo.sv
rtl/core/brf_checker.sv
verif/byte_ring_fifo_tb.sv
